FILE: sv/gfis_pkg.sv
package gfis_pkg;

   // Fixed field widths of the request and response channels and the column count.
   localparam int SLOT_W   = 6;
   localparam int SIZE_W   = 32;
   localparam int VALUE_W  = 64;
   localparam int COLUMN_W = 6;
   localparam int COUNT_W  = 7;

   // Request command codes.
   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_LOAD      = 1'b1;

endpackage

FILE: sv/gfis_ram.sv
module gfis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/gfis_cursor.sv
module gfis_cursor #(
   parameter int MAX_COLUMNS = 64,
   parameter int INDEX_BITS  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cmd,
   input  logic                               req_row_start,
   input  logic [gfis_pkg::SLOT_W-1:0]        req_slot,
   input  logic [gfis_pkg::SIZE_W-1:0]        req_size_value,
   input  logic [INDEX_BITS-1:0]              req_global_index,
   input  logic [gfis_pkg::VALUE_W-1:0]       req_value,
   // Clamped number of columns in use.
   input  logic [$clog2(MAX_COLUMNS+1)-1:0]   count,
   // Size table port.
   output logic                               ram_wr_en,
   output logic [$clog2(MAX_COLUMNS)-1:0]     ram_wr_addr,
   output logic [gfis_pkg::SIZE_W-1:0]        ram_wr_data,
   output logic                               ram_rd_en,
   output logic [$clog2(MAX_COLUMNS)-1:0]     ram_rd_addr,
   input  logic [gfis_pkg::SIZE_W-1:0]        ram_rd_data,
   // Result toward the output stage.
   output logic                               res_valid,
   input  logic                               res_ready,
   output logic [gfis_pkg::COLUMN_W-1:0]      res_column,
   output logic [INDEX_BITS-1:0]              res_local_index,
   output logic [gfis_pkg::VALUE_W-1:0]       res_value,
   output logic                               res_out_of_range
);

   import gfis_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS);
   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int SUM_W  = ((INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W) + 1;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type              state_ff, state_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [INDEX_BITS-1:0]  off_ff, off_in;
   logic [INDEX_BITS-1:0]  prev_ff, prev_in;
   logic [INDEX_BITS-1:0]  gi_ff, gi_in;
   logic [VALUE_W-1:0]     value_ff, value_in;

   logic                   accept;
   logic                   sentinel;
   logic [INDEX_BITS-1:0]  prev_eff;
   logic                   restart;
   logic [COL_W-1:0]       start_col;
   logic                   slot_ok;
   logic                   in_range;
   logic [SUM_W-1:0]       sum;
   logic                   step;
   logic [COL_W-1:0]       col_next;

   // Only one request is in the walk at a time, so a load never meets a pending read.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Cursor restart on a row start or on an index that does not move forward.
   assign sentinel  = &req_global_index;
   assign prev_eff  = req_row_start ? '0 : prev_ff;
   assign restart   = req_row_start || (!sentinel && (req_global_index <= prev_eff));
   assign start_col = restart ? '0 : col_ff;
   assign slot_ok   = (32'(req_slot) < 32'(MAX_COLUMNS));

   // Walk step: move past the current column while the index lies beyond its end.
   assign in_range = (col_ff < count);
   assign sum      = SUM_W'(off_ff) + SUM_W'(ram_rd_data);
   assign step     = in_range && (SUM_W'(gi_ff) >= sum);
   assign col_next = col_ff + COL_W'(1);

   // Size table accesses.
   assign ram_wr_en   = accept && (req_cmd == CMD_LOAD) && slot_ok;
   assign ram_wr_addr = ADDR_W'(req_slot);
   assign ram_wr_data = req_size_value;

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = start_col[ADDR_W-1:0];
      if (state_ff == ST_IDLE) begin
         ram_rd_en   = accept && (req_cmd == CMD_TRANSLATE) && !sentinel;
         ram_rd_addr = start_col[ADDR_W-1:0];
      end else begin
         ram_rd_en   = step;
         ram_rd_addr = col_next[ADDR_W-1:0];
      end
   end

   // Result of a finished walk.
   assign res_valid        = (state_ff == ST_LOOKUP) && !step;
   assign res_out_of_range = !in_range;
   assign res_column       = in_range ? COLUMN_W'(col_ff) : '0;
   assign res_local_index  = in_range ? (gi_ff - off_ff) : '0;
   assign res_value        = value_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      off_in   = off_ff;
      prev_in  = prev_ff;
      gi_in    = gi_ff;
      value_in = value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_TRANSLATE)) begin
               if (restart) begin
                  col_in  = '0;
                  off_in  = '0;
                  prev_in = '0;
               end
               if (!sentinel) begin
                  prev_in  = req_global_index;
                  gi_in    = req_global_index;
                  value_in = req_value;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (step) begin
               col_in = col_next;
               off_in = INDEX_BITS'(sum);
            end else if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, cursor and captured request.
   always_ff @(posedge clock) begin
      gi_ff    <= gi_in;
      value_ff <= value_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         off_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

FILE: sv/gfis_out_stage.sv
module gfis_out_stage #(
   parameter int INDEX_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Result from the cursor.
   input  logic                          res_valid,
   output logic                          res_ready,
   input  logic [gfis_pkg::COLUMN_W-1:0] res_column,
   input  logic [INDEX_BITS-1:0]         res_local_index,
   input  logic [gfis_pkg::VALUE_W-1:0]  res_value,
   input  logic                          res_out_of_range,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gfis_pkg::COLUMN_W-1:0] rsp_column,
   output logic [INDEX_BITS-1:0]         rsp_local_index,
   output logic [gfis_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic                          rsp_out_of_range
);

   import gfis_pkg::*;

   logic                  valid_ff;
   logic [COLUMN_W-1:0]   column_ff;
   logic [INDEX_BITS-1:0] local_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic                  oor_ff;
   logic                  push;

   // The register takes a new result when empty or when its result leaves now.
   assign res_ready = !valid_ff || !rsp_stall;
   assign push      = res_valid && res_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         column_ff <= res_column;
         local_ff  <= res_local_index;
         value_ff  <= res_value;
         oor_ff    <= res_out_of_range;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_column       = column_ff;
   assign rsp_local_index  = local_ff;
   assign rsp_value_out    = value_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

FILE: sv/global_feature_index_splitter.sv
// Global feature index splitter.
// Requests come in on the req_ channel (valid/stall); req_cmd selects a size
// load into the column table or the translation of one sparse entry. Each
// translated entry gives one response on the rsp_ channel with its column,
// local index, the value passed through and an out-of-range flag; an entry
// whose index is all ones gives no response. csr_wr_en writes the number of
// columns in use; the user must do so only while no request is in flight, as
// the block does not enforce this. Loads and skipped entries leave the cursor
// idle; a translation holds req_stall until its result is taken, and each
// column step is one read of the size table followed by one add and compare.
// A response appears on rsp_valid once the output register takes it. The
// output register holds one response, so the block takes the next request
// while that response waits; a stall longer than one translation backs up to
// req_stall. Reset puts the cursor at column 0 with offset and previous index
// zero and sets the column count to 1. The size table is not cleared; every
// column in use must be loaded before entries are translated.
module global_feature_index_splitter #(
   parameter int MAX_COLUMNS = 64,
   parameter int INDEX_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic                          req_row_start,
   input  logic [gfis_pkg::SLOT_W-1:0]   req_slot,
   input  logic [gfis_pkg::SIZE_W-1:0]   req_size_value,
   input  logic [INDEX_BITS-1:0]         req_global_index,
   input  logic [gfis_pkg::VALUE_W-1:0]  req_value,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gfis_pkg::COLUMN_W-1:0] rsp_column,
   output logic [INDEX_BITS-1:0]         rsp_local_index,
   output logic [gfis_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic                          rsp_out_of_range,
   // Column count register.
   input  logic                          csr_wr_en,
   input  logic [gfis_pkg::COUNT_W-1:0]  csr_wr_data
);

   import gfis_pkg::*;

   localparam int ADDR_W = $clog2(MAX_COLUMNS);
   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);

   logic [COUNT_W-1:0]    count_ff;
   logic [COL_W-1:0]      count_use;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [SIZE_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [SIZE_W-1:0]     ram_rd_data;
   logic                  res_valid;
   logic                  res_ready;
   logic [COLUMN_W-1:0]   res_column;
   logic [INDEX_BITS-1:0] res_local_index;
   logic [VALUE_W-1:0]    res_value;
   logic                  res_out_of_range;

   // Column count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // A count of zero acts as one, and one above the table depth as the depth.
   always_comb begin
      if (count_ff == '0) begin
         count_use = COL_W'(1);
      end else if (32'(count_ff) > 32'(MAX_COLUMNS)) begin
         count_use = COL_W'(MAX_COLUMNS);
      end else begin
         count_use = COL_W'(count_ff);
      end
   end

   gfis_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (MAX_COLUMNS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gfis_cursor #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_cursor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_row_start    (req_row_start),
      .req_slot         (req_slot),
      .req_size_value   (req_size_value),
      .req_global_index (req_global_index),
      .req_value        (req_value),
      .count            (count_use),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res_column       (res_column),
      .res_local_index  (res_local_index),
      .res_value        (res_value),
      .res_out_of_range (res_out_of_range)
   );

   gfis_out_stage #(
      .INDEX_BITS (INDEX_BITS)
   ) u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res_column       (res_column),
      .res_local_index  (res_local_index),
      .res_value        (res_value),
      .res_out_of_range (res_out_of_range),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column       (rsp_column),
      .rsp_local_index  (rsp_local_index),
      .rsp_value_out    (rsp_value_out),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
